// File: rtl/qsm_pkg.sv
// Shared types and constants for the dual quadrature speed meter.
// No dependencies; compiled first.
package qsm_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int HIST_LEN        = 5;
  localparam int SPEED_W         = 16;
  localparam int MEAN_W          = 17;
  localparam int FIFO_DEPTH      = 8;

  localparam logic KIND_PIN  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic sample;   // pin sample transaction accepted
    logic tick;     // speed tick transaction accepted
  } dec_ctrl_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [MEAN_W-1:0]  mean_speed_halves;
  } out_item_t;

endpackage

// File: rtl/qsm_if.sv
// Valid/ready channel interfaces for the speed meter's input and result streams.
// Depends on qsm_pkg.
interface qsm_in_if;
  import qsm_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  logic left_a;
  logic left_b;
  logic right_a;
  logic right_b;

  modport source (output valid, kind, left_a, left_b, right_a, right_b, input ready);
  modport sink   (input valid, kind, left_a, left_b, right_a, right_b, output ready);
endinterface

interface qsm_out_if;
  import qsm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] left_speed;
  logic signed [SPEED_W-1:0] right_speed;
  logic signed [MEAN_W-1:0]  mean_speed_halves;

  modport source (output valid, left_speed, right_speed, mean_speed_halves, input ready);
  modport sink   (input valid, left_speed, right_speed, mean_speed_halves, output ready);
endinterface

// File: rtl/qsm_decoder.sv
// x2 quadrature decoder for one encoder: A-edge counting with saturating counter.
// Depends on qsm_pkg.
module qsm_decoder #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qsm_pkg::dec_ctrl_t            ctrl,
  input  logic                          pin_a,
  input  logic                          pin_b,
  output logic signed [COUNT_WIDTH-1:0] count
);
  import qsm_pkg::*;

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic                          prev_a_r, prev_b_r;
  logic signed [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                          step_up, step_dn;

  // direction comes from the stored B level, not the new one
  assign step_up = (!prev_a_r &&  pin_a && !prev_b_r) || (prev_a_r && !pin_a &&  prev_b_r);
  assign step_dn = (!prev_a_r &&  pin_a &&  prev_b_r) || (prev_a_r && !pin_a && !prev_b_r);

  always_comb begin
    count_nxt = count_r;
    if (ctrl.tick) begin
      count_nxt = '0;
    end else if (ctrl.sample) begin
      if (step_up && count_r != CNT_MAX) begin
        count_nxt = count_r + COUNT_WIDTH'(1);
      end else if (step_dn && count_r != CNT_MIN) begin
        count_nxt = count_r - COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      prev_b_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (ctrl.sample) begin
        prev_a_r <= pin_a;
        prev_b_r <= pin_b;
      end
    end
  end

  assign count = count_r;

endmodule

// File: rtl/qsm_history.sv
// Five-deep period history for one side and its trimmed sum (sum less max and min).
// Depends on qsm_pkg.
module qsm_history #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic signed [COUNT_WIDTH-1:0] count,
  output logic signed [COUNT_WIDTH+1:0] trim
);
  import qsm_pkg::*;

  localparam int SW = COUNT_WIDTH + 3;

  logic signed [COUNT_WIDTH-1:0] hist_r [HIST_LEN];
  logic signed [SW-1:0]          sum, mx, mn, diff;
  logic signed [COUNT_WIDTH+1:0] trim_r;

  always_comb begin
    sum = SW'(hist_r[0]);
    mx  = SW'(hist_r[0]);
    mn  = SW'(hist_r[0]);
    for (int i = 1; i < HIST_LEN; i++) begin
      sum = sum + SW'(hist_r[i]);
      if (SW'(hist_r[i]) > mx) mx = SW'(hist_r[i]);
      if (SW'(hist_r[i]) < mn) mn = SW'(hist_r[i]);
    end
    diff = sum - mx - mn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_LEN; i++) hist_r[i] <= '0;
    end else if (push) begin
      for (int i = 0; i < HIST_LEN - 1; i++) hist_r[i] <= hist_r[i+1];
      hist_r[HIST_LEN-1] <= count;
    end
  end

  // three middle values fit in two extra bits
  always_ff @(posedge clk) begin
    trim_r <= diff[COUNT_WIDTH+1:0];
  end

  assign trim = trim_r;

endmodule

// File: rtl/qsm_div3.sv
// Signed divide by 3, truncating toward zero: magnitude, reciprocal multiply, sign.
// Depends on qsm_pkg.
module qsm_div3 #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [COUNT_WIDTH+1:0] trim,
  output logic signed [COUNT_WIDTH-1:0] quot
);
  import qsm_pkg::*;

  localparam int MW = COUNT_WIDTH + 1;       // magnitude width
  localparam int K  = MW + 1;                // reciprocal shift
  localparam logic [63:0] RECIP64 = ((64'd1 << K) + 64'd2) / 64'd3;  // ceil(2^K/3)
  localparam int RW = K - 1;
  localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

  logic [MW-1:0]          mag_r;
  logic                   neg_r, neg2_r;
  logic [COUNT_WIDTH+1:0] abs_v;
  logic [MW+RW-1:0]       prod;
  logic [COUNT_WIDTH-1:0] q_r;
  logic [COUNT_WIDTH:0]   q_ext;

  assign abs_v = trim[COUNT_WIDTH+1] ? (~trim + 1'b1) : trim;
  assign prod  = (MW+RW)'(mag_r) * (MW+RW)'(RECIP);

  always_ff @(posedge clk) begin
    mag_r  <= abs_v[MW-1:0];
    neg_r  <= trim[COUNT_WIDTH+1];
    q_r    <= prod[K +: COUNT_WIDTH];
    neg2_r <= neg_r;
  end

  assign q_ext = neg2_r ? (~{1'b0, q_r} + 1'b1) : {1'b0, q_r};
  assign quot  = q_ext[COUNT_WIDTH-1:0];

endmodule

// File: rtl/qsm_out_fifo.sv
// Result queue that decouples the arithmetic pipeline from the result channel.
// Depends on qsm_pkg and qsm_out_if.
module qsm_out_fifo (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     push,
  input  qsm_pkg::out_item_t                       din,
  output logic [$clog2(qsm_pkg::FIFO_DEPTH+1)-1:0] level,
  qsm_out_if.source                                out_ch
);
  import qsm_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  out_item_t       mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [LW-1:0]   level_r;
  logic            pop;

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= din;
  end

  assign out_ch.valid             = (level_r != '0);
  assign out_ch.left_speed        = mem_r[rptr_r].left_speed;
  assign out_ch.right_speed       = mem_r[rptr_r].right_speed;
  assign out_ch.mean_speed_halves = mem_r[rptr_r].mean_speed_halves;
  assign level                    = level_r;

endmodule

// File: rtl/dual_quadrature_speed_meter.sv
// Dual quadrature speed meter: x2 decoding of two encoders, trimmed-mean speed output.
// Depends on qsm_pkg, qsm_if, qsm_decoder, qsm_history, qsm_div3, qsm_out_fifo.
//
// Input channel in_ch: each transaction is either a pin sample (kind = 0) carrying
// the A/B levels of both encoders, or a speed tick (kind = 1). A sample updates
// the edge counters and gives no result. A tick pushes both counters into their
// five-entry histories, clears them and yields one result transaction on out_ch:
// per-side sum of the history less its maximum and minimum, divided by 3 toward
// zero, and the sum of both sides (mean speed in halves).
// Throughput: one input transaction every cycle while in_ch.ready is high. The
// histories load at the edge that accepts the tick; the result then passes the trim,
// magnitude and multiply registers and the result queue before it shows on out_ch.
// The reciprocal multiply in the divide-by-3 stage sets the clock.
// Results wait in an eight-entry queue; in_ch.ready drops only while the queue
// plus the ticks still in the pipeline would fill it, so a stalled receiver
// holds off input after enough unread results have gathered, never before.
// Reset (rst_n low, synchronous) clears counters, stored pin levels, histories,
// pipeline valids and the queue.
module dual_quadrature_speed_meter #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  qsm_in_if.sink  in_ch,
  qsm_out_if.source out_ch
);
  import qsm_pkg::*;

  localparam int LW = $clog2(FIFO_DEPTH + 1);
  localparam int OW = $clog2(FIFO_DEPTH + 5);
  localparam int EW = (COUNT_WIDTH + 1 > MEAN_W) ? COUNT_WIDTH + 1 : MEAN_W;

  logic                          in_acc;
  dec_ctrl_t                     ctrl;
  logic                          v1_r, v2_r, v3_r, v4_r;
  logic signed [COUNT_WIDTH-1:0] l_cnt, r_cnt;
  logic signed [COUNT_WIDTH+1:0] l_trim, r_trim;
  logic signed [COUNT_WIDTH-1:0] l_q, r_q;
  logic signed [EW-1:0]          l_x, r_x, s_x;
  out_item_t                     item;
  logic [LW-1:0]                 level;
  logic [OW-1:0]                 occ;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ctrl.sample = in_acc && (in_ch.kind == KIND_PIN);
  assign ctrl.tick   = in_acc && (in_ch.kind == KIND_TICK);

  // queue entries plus ticks still travelling through the pipeline
  assign occ = OW'(level) + OW'(v1_r) + OW'(v2_r) + OW'(v3_r) + OW'(v4_r);
  assign in_ch.ready = (occ < OW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= ctrl.tick;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  qsm_decoder #(.COUNT_WIDTH(COUNT_WIDTH)) u_dec_l (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .pin_a(in_ch.left_a), .pin_b(in_ch.left_b), .count(l_cnt)
  );

  qsm_decoder #(.COUNT_WIDTH(COUNT_WIDTH)) u_dec_r (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
    .pin_a(in_ch.right_a), .pin_b(in_ch.right_b), .count(r_cnt)
  );

  qsm_history #(.COUNT_WIDTH(COUNT_WIDTH)) u_hist_l (
    .clk(clk), .rst_n(rst_n), .push(ctrl.tick), .count(l_cnt), .trim(l_trim)
  );

  qsm_history #(.COUNT_WIDTH(COUNT_WIDTH)) u_hist_r (
    .clk(clk), .rst_n(rst_n), .push(ctrl.tick), .count(r_cnt), .trim(r_trim)
  );

  qsm_div3 #(.COUNT_WIDTH(COUNT_WIDTH)) u_div_l (
    .clk(clk), .trim(l_trim), .quot(l_q)
  );

  qsm_div3 #(.COUNT_WIDTH(COUNT_WIDTH)) u_div_r (
    .clk(clk), .trim(r_trim), .quot(r_q)
  );

  assign l_x = EW'(l_q);
  assign r_x = EW'(r_q);
  assign s_x = l_x + r_x;

  assign item.left_speed        = l_x[SPEED_W-1:0];
  assign item.right_speed       = r_x[SPEED_W-1:0];
  assign item.mean_speed_halves = s_x[MEAN_W-1:0];

  qsm_out_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(v4_r), .din(item), .level(level), .out_ch(out_ch)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(FIFO_DEPTH))
    else $error("result queue level beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(v4_r && level == LW'(FIFO_DEPTH) && !out_ch.ready))
    else $error("result pushed into a full queue");

  a_tick_flows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.tick |=> v1_r ##1 v2_r ##1 v3_r ##1 v4_r)
    else $error("tick lost in pipeline");

  a_sample_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_PIN) |=> !v1_r)
    else $error("pin sample started a result");

endmodule

// File: tb/sv/speed_meter_checker.sv
// Checker for the dual quadrature speed meter: watches both channels, predicts results.
// Depends on qsm_pkg and the qsm_in_if / qsm_out_if interfaces.
module speed_meter_checker (
  input  logic clk,
  input  logic rst_n,
  qsm_in_if    in_ch,
  qsm_out_if   out_ch,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import qsm_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam logic signed [CW-1:0] CNT_HI  = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CNT_LO  = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CNT_ONE = 1;

  // index 0 = left encoder, 1 = right encoder
  logic                 prev_a [2];
  logic                 prev_b [2];
  logic signed [CW-1:0] edge_cnt [2];
  logic signed [CW-1:0] period_hist [2][HIST_LEN];

  out_item_t speed_q [$];
  out_item_t want;
  int        left_spd, right_spd, spd_sum;

  task automatic report(input string what);
    $display("[%0t] speed meter mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // x2 decode: only A edges count, direction from the stored B level
  task automatic count_edge(input int s, input logic a, input logic b);
    int step;
    step = 0;
    if (!prev_a[s] && a) begin
      step = prev_b[s] ? -1 : 1;
    end else if (prev_a[s] && !a) begin
      step = prev_b[s] ? 1 : -1;
    end
    if (step > 0 && edge_cnt[s] < CNT_HI) begin
      edge_cnt[s] = edge_cnt[s] + CNT_ONE;
    end else if (step < 0 && edge_cnt[s] > CNT_LO) begin
      edge_cnt[s] = edge_cnt[s] - CNT_ONE;
    end
    prev_a[s] = a;
    prev_b[s] = b;
  endtask

  // shift the period count in, clear it, return the trimmed mean of the history
  task automatic push_period(input int s, output int speed);
    int                   sum;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    for (int i = 0; i < HIST_LEN - 1; i++) period_hist[s][i] = period_hist[s][i+1];
    period_hist[s][HIST_LEN-1] = edge_cnt[s];
    edge_cnt[s] = '0;
    sum = 0;
    hi  = period_hist[s][0];
    lo  = period_hist[s][0];
    for (int i = 0; i < HIST_LEN; i++) begin
      sum = sum + int'(period_hist[s][i]);
      if (period_hist[s][i] > hi) hi = period_hist[s][i];
      if (period_hist[s][i] < lo) lo = period_hist[s][i];
    end
    speed = (sum - int'(hi) - int'(lo)) / 3;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        prev_a[s]   = 1'b0;
        prev_b[s]   = 1'b0;
        edge_cnt[s] = '0;
        for (int i = 0; i < HIST_LEN; i++) period_hist[s][i] = '0;
      end
      speed_q.delete();
      mismatches = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == KIND_PIN) begin
          count_edge(0, in_ch.left_a, in_ch.left_b);
          count_edge(1, in_ch.right_a, in_ch.right_b);
        end else begin
          push_period(0, left_spd);
          push_period(1, right_spd);
          spd_sum                = left_spd + right_spd;
          want.left_speed        = left_spd[SPEED_W-1:0];
          want.right_speed       = right_spd[SPEED_W-1:0];
          want.mean_speed_halves = spd_sum[MEAN_W-1:0];
          speed_q.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (speed_q.size() == 0) begin
          report($sformatf("result transaction with nothing outstanding (%0d %0d %0d)",
                           out_ch.left_speed, out_ch.right_speed, out_ch.mean_speed_halves));
        end else begin
          want = speed_q.pop_front();
          if (out_ch.left_speed !== want.left_speed)
            report($sformatf("left_speed got %0d, expected %0d",
                             out_ch.left_speed, want.left_speed));
          if (out_ch.right_speed !== want.right_speed)
            report($sformatf("right_speed got %0d, expected %0d",
                             out_ch.right_speed, want.right_speed));
          if (out_ch.mean_speed_halves !== want.mean_speed_halves)
            report($sformatf("mean_speed_halves got %0d, expected %0d",
                             out_ch.mean_speed_halves, want.mean_speed_halves));
        end
      end
    end
    pending = speed_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the speed meter testbench: clock, reset, encoder stimulus, receiver and verdict.
// Depends on qsm_pkg, qsm_if, dual_quadrature_speed_meter and speed_meter_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qsm_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum int {WALK_HOLD, WALK_FWD, WALK_BACK, RUN_UP, RUN_DOWN, PIN_NOISE} pin_move_e;

  logic clk = 1'b0;
  logic rst_n;

  qsm_in_if  in_ch ();
  qsm_out_if out_ch ();

  int mismatches;
  int pending;

  int tx_idle_pct = 18;
  int rx_idle_pct = 77;
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  // encoder levels last put on the pins, index 0 = left, 1 = right
  logic lvl_a [2] = '{1'b0, 1'b0};
  logic lvl_b [2] = '{1'b0, 1'b0};

  always #2 clk = ~clk;

  dual_quadrature_speed_meter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  speed_meter_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  task automatic send_item(input logic kind, input logic la, input logic lb,
                           input logic ra, input logic rb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.left_a  <= la;
    in_ch.left_b  <= lb;
    in_ch.right_a <= ra;
    in_ch.right_b <= rb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_pins();
    send_item(KIND_PIN, lvl_a[0], lvl_b[0], lvl_a[1], lvl_b[1]);
  endtask

  // pin levels ride along on a tick but must be ignored
  task automatic send_tick();
    send_item(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic set_levels(input logic la, input logic lb, input logic ra, input logic rb);
    lvl_a[0] = la;
    lvl_b[0] = lb;
    lvl_a[1] = ra;
    lvl_b[1] = rb;
    send_pins();
  endtask

  // forward Gray order is 00 -> 10 -> 11 -> 01; the RUN moves flip A on every
  // sample and set B so that each A edge counts the same way
  task automatic move_side(input int s, input pin_move_e mv);
    case (mv)
      WALK_FWD: begin
        if (lvl_a[s] == lvl_b[s]) lvl_a[s] = ~lvl_a[s];
        else lvl_b[s] = ~lvl_b[s];
      end
      WALK_BACK: begin
        if (lvl_a[s] == lvl_b[s]) lvl_b[s] = ~lvl_b[s];
        else lvl_a[s] = ~lvl_a[s];
      end
      RUN_UP: begin
        lvl_a[s] = ~lvl_a[s];
        lvl_b[s] = lvl_a[s];
      end
      RUN_DOWN: begin
        lvl_a[s] = ~lvl_a[s];
        lvl_b[s] = ~lvl_a[s];
      end
      PIN_NOISE: begin
        lvl_a[s] = 1'($urandom_range(1));
        lvl_b[s] = 1'($urandom_range(1));
      end
      default: begin
      end
    endcase
  endtask

  // bursts of encoder motion, each usually closed by a speed tick
  task automatic run_random(input int n_items);
    int        done;
    int        len;
    int        r;
    pin_move_e mv [2];
    done = 0;
    while (done < n_items) begin
      for (int s = 0; s < 2; s++) begin
        r = $urandom_range(99);
        if (r < 30) mv[s] = WALK_FWD;
        else if (r < 60) mv[s] = WALK_BACK;
        else if (r < 72) mv[s] = RUN_UP;
        else if (r < 84) mv[s] = RUN_DOWN;
        else if (r < 92) mv[s] = WALK_HOLD;
        else mv[s] = PIN_NOISE;
      end
      len = $urandom_range(1, 16);
      repeat (len) begin
        for (int s = 0; s < 2; s++) begin
          if ($urandom_range(99) < 12) move_side(s, PIN_NOISE);
          else move_side(s, mv[s]);
        end
        send_pins();
        done++;
      end
      if ($urandom_range(99) < 85) begin
        send_tick();
        done++;
      end
      if ($urandom_range(99) < 8) begin
        send_tick();
        done++;
      end
    end
  endtask

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("stalled for %0d cycles, %0d results outstanding", quiet_cycles, pending);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_PIN;
    in_ch.left_a  <= 1'b0;
    in_ch.left_b  <= 1'b0;
    in_ch.right_a <= 1'b0;
    in_ch.right_b <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty history, ignored pins on a tick, each edge direction,
    // B-only changes and A and B changing together
    send_item(KIND_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
    set_levels(1'b0, 1'b0, 1'b0, 1'b0);
    set_levels(1'b1, 1'b0, 1'b1, 1'b0);
    set_levels(1'b1, 1'b1, 1'b1, 1'b1);
    set_levels(1'b0, 1'b1, 1'b0, 1'b0);
    set_levels(1'b1, 1'b1, 1'b1, 1'b1);
    set_levels(1'b0, 1'b0, 1'b0, 1'b1);
    send_item(KIND_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
    set_levels(1'b0, 1'b1, 1'b1, 1'b1);
    set_levels(1'b1, 1'b1, 1'b0, 1'b1);
    set_levels(1'b0, 1'b0, 1'b1, 1'b0);
    set_levels(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick();
    send_item(KIND_TICK, 1'b1, 1'b0, 1'b0, 1'b1);
    set_levels(1'b0, 1'b1, 1'b1, 1'b0);
    send_tick();
    send_tick();
    send_tick();
    run_random(200);

    tx_idle_pct <= 77;
    rx_idle_pct <= 18;
    run_random(200);

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    // long receiver hold-off while ticks keep coming, so the result queue fills
    hold_seq <= hold_seq + 1;
    repeat (20) send_tick();
    run_random(40);
    run_random(120);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
